FILE: sv/lct_pkg.sv
// Shared constants and types for the Levi-Civita tensor generator.
// Used by lct_ctrl, lct_datapath and levi_civita_tensor_generator.
`default_nettype none

package lct_pkg;

  // Odometer geometry
  localparam int MAX_RANK = 8;
  localparam int DIGIT_W  = $clog2(MAX_RANK);
  localparam int STEP_W   = $clog2(MAX_RANK);
  localparam int N_W      = DIGIT_W + 1;
  localparam int RANK_W   = 4;
  localparam int MIN_RANK = 2;

  localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(3);

  // Entry codes (two's complement, 2 bits)
  localparam logic signed [1:0] ENTRY_ZERO = 2'sb00;
  localparam logic signed [1:0] ENTRY_POS  = 2'sb01;
  localparam logic signed [1:0] ENTRY_NEG  = 2'sb11;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;
    logic clear;
    logic step;
    logic load;
  } lct_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_step;
  } lct_stat_t;

endpackage

`default_nettype wire

FILE: sv/lct_datapath.sv
// Datapath: rank register, odometer digits, per-digit permutation/parity step
// and the output register. Depends on lct_pkg.
`default_nettype none

module lct_datapath
  import lct_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   tensor_rank_we,
  input  wire logic [RANK_W-1:0]      tensor_rank_wdata,
  input  wire lct_cmd_t               cmd,
  output lct_stat_t                   stat,
  output logic signed [1:0]           entry_value,
  output logic                        last_entry
);

  logic [RANK_W-1:0]   rank;
  logic [DIGIT_W-1:0]  digits [MAX_RANK];
  logic [STEP_W-1:0]   step;
  logic [MAX_RANK-1:0] seen;
  logic                ok;
  logic                par;
  logic                carry;

  logic [N_W-1:0]      n;
  logic [DIGIT_W-1:0]  d;
  logic [N_W-1:0]      d_inc;
  logic                in_range;
  logic                ok_next;
  logic                par_next;
  logic                carry_next;
  logic                inv;
  logic [DIGIT_W-1:0]  d_next;

  // Clamp the rank to the supported range
  always_comb begin
    if (rank < RANK_W'(MIN_RANK)) begin
      n = N_W'(MIN_RANK);
    end else if (rank > RANK_W'(MAX_RANK)) begin
      n = N_W'(MAX_RANK);
    end else begin
      n = N_W'(rank);
    end
  end

  assign stat.last_step = (N_W'(step) == n - N_W'(1));

  // One digit per cycle while stepping: range, duplicate, inversion parity and carry
  always_comb begin
    d        = digits[step];
    d_inc    = N_W'(d) + N_W'(1);
    in_range = N_W'(d) < n;
    ok_next  = ok & in_range & ~seen[d];
    inv      = 1'b0;
    for (int j = 0; j < MAX_RANK; j++) begin
      if ((N_W'(j) > N_W'(step)) && (N_W'(j) < n) && (digits[j] < d)) begin
        inv = ~inv;
      end
    end
    par_next = par ^ inv;
    d_next   = d;
    carry_next = carry;
    if (carry) begin
      if (d_inc < n) begin
        d_next     = d_inc[DIGIT_W-1:0];
        carry_next = 1'b0;
      end else begin
        d_next     = '0;
      end
    end
  end

  // Rank register and odometer
  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= RANK_RESET;
      for (int k = 0; k < MAX_RANK; k++) begin
        digits[k] <= '0;
      end
    end else if (tensor_rank_we) begin
      rank <= tensor_rank_wdata;
      for (int k = 0; k < MAX_RANK; k++) begin
        digits[k] <= '0;
      end
    end else if (cmd.start && cmd.clear) begin
      for (int k = 0; k < MAX_RANK; k++) begin
        digits[k] <= '0;
      end
    end else if (cmd.step) begin
      digits[step] <= d_next;
    end
  end

  // Per-item accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= '0;
      seen  <= '0;
      ok    <= 1'b1;
      par   <= 1'b0;
      carry <= 1'b1;
    end else if (cmd.start) begin
      step  <= '0;
      seen  <= '0;
      ok    <= 1'b1;
      par   <= 1'b0;
      carry <= 1'b1;
    end else if (cmd.step) begin
      step        <= step + STEP_W'(1);
      seen[d]     <= 1'b1;
      ok          <= ok_next;
      par         <= par_next;
      carry       <= carry_next;
    end
  end

  // Output register, loaded on the final digit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      entry_value <= ok_next ? (par_next ? ENTRY_NEG : ENTRY_POS) : ENTRY_ZERO;
      last_entry  <= carry_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lct_ctrl.sv
// Controller: accepts items, sequences the digit steps and owns out_valid.
// Depends on lct_pkg.
`default_nettype none

module lct_ctrl
  import lct_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       restart,
  output logic            out_valid,
  input  wire logic       out_stall,
  output lct_cmd_t        cmd,
  input  wire lct_stat_t  stat
);

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_busy;

  assign in_stall = (state != IDLE);
  assign out_busy = out_valid & out_stall;

  // Issue commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          cmd.clear  = restart;
          state_next = RUN;
        end
      end
      RUN: begin
        // hold the final digit until the output register is free
        if (!(stat.last_step && out_busy)) begin
          cmd.step = 1'b1;
          if (stat.last_step) begin
            cmd.load   = 1'b1;
            state_next = IDLE;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.load | out_busy;
    end
  end

endmodule

`default_nettype wire

FILE: sv/levi_civita_tensor_generator.sv
// Levi-Civita tensor entry generator, top level; depends on lct_pkg,
// lct_ctrl and lct_datapath.
// Sequencing: an accepted item walks n odometer digits (n = rank clamped to
// 2..MAX_RANK), one per cycle; the last waits while the output register is busy.
// out_valid is registered with it; in_stall holds off new items until then; the result waits in an output register.
// Reset: rank 3, odometer all zeros, no result pending.
`default_nettype none

module levi_civita_tensor_generator
  import lct_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 tensor_rank_we,
  input  wire logic [RANK_W-1:0]    tensor_rank_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 restart,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [1:0]         entry_value,
  output logic                      last_entry
);

  lct_cmd_t  cmd;
  lct_stat_t stat;

  lct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  lct_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .tensor_rank_we    (tensor_rank_we),
    .tensor_rank_wdata (tensor_rank_wdata),
    .cmd               (cmd),
    .stat              (stat),
    .entry_value       (entry_value),
    .last_entry        (last_entry)
  );

endmodule

`default_nettype wire
